// ===== design/i2cseq_pkg.sv =====
// Shared types and codes for the I2C register transaction sequencer.
// Used by the front classifier, the sequencing back end and the top level.
package i2cseq_pkg;

  // input item modes
  localparam logic [1:0] MODE_REQ  = 2'd0;
  localparam logic [1:0] MODE_CPL  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;
  localparam logic [1:0] MODE_BYTE = 2'd3;

  // transaction kinds
  localparam logic [2:0] KIND_WR_BYTE  = 3'd0;
  localparam logic [2:0] KIND_WR_WORD  = 3'd1;
  localparam logic [2:0] KIND_WR_BLOCK = 3'd2;
  localparam logic [2:0] KIND_RD_BYTE  = 3'd3;
  localparam logic [2:0] KIND_RD_WORD  = 3'd4;
  localparam logic [2:0] KIND_PING     = 3'd5;

  // engine commands
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_RD_ACK  = 3'd3;
  localparam logic [2:0] CMD_RD_NACK = 3'd4;
  localparam logic [2:0] CMD_STOP    = 3'd5;
  localparam logic [2:0] CMD_REINIT  = 3'd6;

  // engine status codes
  localparam logic [7:0] STATUS_MASK     = 8'hF8;
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_RSTART       = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK     = 8'h18;
  localparam logic [7:0] ST_DATA_ACK     = 8'h28;
  localparam logic [7:0] ST_SLAR_ACK     = 8'h40;
  localparam logic [7:0] ST_RX_ACK       = 8'h50;
  localparam logic [7:0] ST_RX_NACK      = 8'h58;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd800;

  localparam int unsigned CMD_Q_DEPTH = 4;
  localparam int unsigned RES_Q_DEPTH = 4;

  typedef enum logic [1:0] {
    CLS_REQ,
    CLS_CPL,
    CLS_TICK,
    CLS_BYTE
  } cls_e;

  // classified item held between front and back
  typedef struct packed {
    cls_e        cls;
    logic [2:0]  kind;
    logic [6:0]  dev;
    logic [7:0]  regad;
    logic [15:0] word;
    logic [7:0]  blen;
    logic [7:0]  status;
    logic [7:0]  edata;
  } item_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  cmd_byte;
    logic        done;
    logic        ok;
    logic [15:0] data;
    logic [15:0] lock;
    logic        last;
  } res_t;

endpackage

// ===== design/i2c_register_transaction_sequencer_top.sv =====
// Path: items and their results pass the registered command and result queues.
// Throughput: one item per cycle while the result queue has room; a timeout item
// holds the back end until both of its result entries are in the result queue.
// Reset: asynchronous, active low; queues empty, sequencer idle, limit 800.
// Depends on i2cseq_pkg, i2cseq_front, i2cseq_fifo and i2cseq_back.
module i2c_register_transaction_sequencer_top import i2cseq_pkg::*; #(
  parameter int unsigned CmdDepth = CMD_Q_DEPTH,
  parameter int unsigned ResDepth = RES_Q_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  kind_i,
  input  logic [6:0]  device_address_i,
  input  logic [7:0]  register_address_i,
  input  logic [15:0] data_word_i,
  input  logic [7:0]  block_length_i,
  input  logic [7:0]  engine_status_i,
  input  logic [7:0]  engine_data_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  command_o,
  output logic [7:0]  command_byte_o,
  output logic        done_res_o,
  output logic        success_o,
  output logic [15:0] read_data_o,
  output logic [15:0] lockup_count_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic  q_push, q_empty, q_pop;
  item_t q_in, q_out;
  logic  r_push, r_full;
  res_t  r_in, r_out;

  assign cfg_ready_o = 1'b1;

  i2cseq_front u_front (
    .push_i             (push),
    .mode_i             (mode_i),
    .kind_i             (kind_i),
    .device_address_i   (device_address_i),
    .register_address_i (register_address_i),
    .data_word_i        (data_word_i),
    .block_length_i     (block_length_i),
    .engine_status_i    (engine_status_i),
    .engine_data_i      (engine_data_i),
    .q_push_o           (q_push),
    .q_item_o           (q_in)
  );

  i2cseq_fifo #(
    .Depth (CmdDepth),
    .T     (item_t)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  i2cseq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .it_empty_i  (q_empty),
    .it_i        (q_out),
    .it_pop_o    (q_pop),
    .res_full_i  (r_full),
    .res_push_o  (r_push),
    .res_o       (r_in)
  );

  i2cseq_fifo #(
    .Depth (ResDepth),
    .T     (res_t)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (r_push),
    .data_i  (r_in),
    .full_o  (r_full),
    .pop_i   (pop),
    .data_o  (r_out),
    .empty_o (empty)
  );

  assign command_o      = r_out.cmd;
  assign command_byte_o = r_out.cmd_byte;
  assign done_res_o     = r_out.done;
  assign success_o      = r_out.ok;
  assign read_data_o    = r_out.data;
  assign lockup_count_o = r_out.lock;
  assign last_o         = r_out.last;

endmodule

// ===== design/i2cseq_fifo.sv =====
// Small synchronous queue used between the sequencer stages and on the result side.
// Stand-alone; entry type and depth come from parameters.
module i2cseq_fifo #(
  parameter int unsigned Depth = 4,
  parameter type         T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T              mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic          push_ok, pop_ok;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_ok) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    unique case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/i2cseq_front.sv =====
// Front end: classifies incoming items and drops malformed requests.
// Depends on i2cseq_pkg for mode, kind and item types.
module i2cseq_front import i2cseq_pkg::*; (
  input  logic        push_i,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  kind_i,
  input  logic [6:0]  device_address_i,
  input  logic [7:0]  register_address_i,
  input  logic [15:0] data_word_i,
  input  logic [7:0]  block_length_i,
  input  logic [7:0]  engine_status_i,
  input  logic [7:0]  engine_data_i,
  output logic        q_push_o,
  output item_t       q_item_o
);

  logic keep;

  always_comb begin
    keep = 1'b1;
    q_item_o.cls = CLS_REQ;
    unique case (mode_i)
      MODE_REQ: begin
        q_item_o.cls = CLS_REQ;
        // kinds above ping mean nothing: drop them here
        keep = (kind_i <= KIND_PING);
      end
      MODE_CPL:  q_item_o.cls = CLS_CPL;
      MODE_TICK: q_item_o.cls = CLS_TICK;
      default:   q_item_o.cls = CLS_BYTE;
    endcase
    q_item_o.kind   = kind_i;
    q_item_o.dev    = device_address_i;
    q_item_o.regad  = register_address_i;
    q_item_o.word   = data_word_i;
    q_item_o.blen   = block_length_i;
    q_item_o.status = engine_status_i & STATUS_MASK;
    q_item_o.edata  = engine_data_i;
  end

  assign q_push_o = push_i && keep;

endmodule

// ===== design/i2cseq_back.sv =====
// Back end: transaction state machine, timeout counter and lockup recovery.
// Depends on i2cseq_pkg; takes classified items and emits result entries.
module i2cseq_back import i2cseq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  input  logic        it_empty_i,
  input  item_t       it_i,
  output logic        it_pop_o,
  input  logic        res_full_i,
  output logic        res_push_o,
  output res_t        res_o
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_START   = 4'd1;
  localparam logic [3:0] PH_SLAW    = 4'd2;
  localparam logic [3:0] PH_REG     = 4'd3;
  localparam logic [3:0] PH_D1      = 4'd4;
  localparam logic [3:0] PH_D2      = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_BLK     = 4'd7;
  localparam logic [3:0] PH_RSTART  = 4'd8;
  localparam logic [3:0] PH_SLAR    = 4'd9;
  localparam logic [3:0] PH_RDACK   = 4'd10;
  localparam logic [3:0] PH_RDNACK  = 4'd11;
  localparam logic [3:0] PH_PINGSLA = 4'd12;

  logic [3:0]  phase_q, phase_d;
  logic [2:0]  kind_q, kind_d;
  logic [6:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic [15:0] wval_q, wval_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  acc_q, acc_d;
  logic [15:0] wait_q, wait_d;
  logic [15:0] lock_q, lock_d;
  logic [15:0] limit_q, limit_d;
  logic        pend_q, pend_d;

  logic        busy;
  logic        iss_en, fin_en, fin_stop, fin_ok;
  logic [2:0]  iss_cmd;
  logic [7:0]  iss_byte;
  logic [3:0]  iss_next;
  logic [15:0] fin_data;
  logic [15:0] wait_inc;
  logic [7:0]  st;

  assign busy     = (phase_q != PH_IDLE) && (phase_q != PH_PAYLOAD);
  assign st       = it_i.status;
  assign wait_inc = wait_q + 16'd1;

  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    dev_d    = dev_q;
    reg_d    = reg_q;
    wval_d   = wval_q;
    left_d   = left_q;
    acc_d    = acc_q;
    wait_d   = wait_q;
    lock_d   = lock_q;
    limit_d  = cfg_valid_i ? cfg_data_i : limit_q;
    pend_d   = pend_q;
    it_pop_o = 1'b0;
    iss_en   = 1'b0;
    iss_cmd  = CMD_NONE;
    iss_byte = 8'd0;
    iss_next = phase_q;
    fin_en   = 1'b0;
    fin_stop = 1'b1;
    fin_ok   = 1'b0;
    fin_data = 16'd0;
    res_push_o     = 1'b0;
    res_o.cmd      = CMD_NONE;
    res_o.cmd_byte = 8'd0;
    res_o.done     = 1'b0;
    res_o.ok       = 1'b0;
    res_o.data     = 16'd0;
    res_o.lock     = lock_q;
    res_o.last     = 1'b1;

    if (pend_q) begin
      // second half of a timeout recovery
      if (!res_full_i) begin
        res_push_o = 1'b1;
        res_o.cmd  = CMD_REINIT;
        res_o.done = 1'b1;
        pend_d     = 1'b0;
      end
    end else if (!it_empty_i && !res_full_i) begin
      it_pop_o = 1'b1;
      unique case (it_i.cls)
        CLS_REQ: begin
          if (phase_q == PH_IDLE) begin
            kind_d   = it_i.kind;
            dev_d    = it_i.dev;
            reg_d    = it_i.regad;
            wval_d   = it_i.word;
            left_d   = it_i.blen;
            acc_d    = 8'd0;
            iss_en   = 1'b1;
            iss_cmd  = CMD_START;
            iss_next = PH_START;
          end
        end
        CLS_CPL: begin
          if (busy) begin
            unique case (phase_q)
              PH_START: begin
                if (st != ST_START) begin
                  fin_en   = 1'b1;
                  fin_stop = (kind_q == KIND_PING);
                end else begin
                  iss_en   = 1'b1;
                  iss_cmd  = CMD_WRITE;
                  iss_byte = {dev_q, 1'b0};
                  iss_next = (kind_q == KIND_PING) ? PH_PINGSLA : PH_SLAW;
                end
              end
              PH_PINGSLA: begin
                fin_en = 1'b1;
                fin_ok = (st == ST_SLAW_ACK);
              end
              PH_SLAW: begin
                if (st != ST_SLAW_ACK) begin
                  fin_en = 1'b1;
                end else begin
                  iss_en   = 1'b1;
                  iss_cmd  = CMD_WRITE;
                  iss_byte = reg_q;
                  iss_next = PH_REG;
                end
              end
              PH_REG: begin
                iss_en   = 1'b1;
                iss_cmd  = CMD_WRITE;
                iss_next = PH_D1;
                priority if (st != ST_DATA_ACK) begin
                  iss_en = 1'b0;
                  fin_en = 1'b1;
                end else if (kind_q == KIND_WR_BYTE) begin
                  iss_byte = wval_q[7:0];
                end else if (kind_q == KIND_WR_WORD) begin
                  iss_byte = wval_q[15:8];
                end else if (kind_q == KIND_WR_BLOCK) begin
                  iss_byte = left_q;
                end else begin
                  iss_cmd  = CMD_START;
                  iss_next = PH_RSTART;
                end
              end
              PH_D1: begin
                priority if (st != ST_DATA_ACK) begin
                  fin_en = 1'b1;
                end else if (kind_q == KIND_WR_WORD) begin
                  iss_en   = 1'b1;
                  iss_cmd  = CMD_WRITE;
                  iss_byte = wval_q[7:0];
                  iss_next = PH_D2;
                end else if (kind_q == KIND_WR_BLOCK && left_q != 8'd0) begin
                  phase_d = PH_PAYLOAD;
                end else begin
                  fin_en = 1'b1;
                  fin_ok = 1'b1;
                end
              end
              PH_D2: begin
                fin_en = 1'b1;
                fin_ok = (st == ST_DATA_ACK);
              end
              PH_BLK: begin
                if (st != ST_DATA_ACK) begin
                  fin_en = 1'b1;
                end else begin
                  left_d = left_q - 8'd1;
                  if (left_d != 8'd0) begin
                    phase_d = PH_PAYLOAD;
                  end else begin
                    fin_en = 1'b1;
                    fin_ok = 1'b1;
                  end
                end
              end
              PH_RSTART: begin
                if (st != ST_RSTART) begin
                  fin_en   = 1'b1;
                  fin_stop = (kind_q == KIND_RD_WORD);
                end else begin
                  iss_en   = 1'b1;
                  iss_cmd  = CMD_WRITE;
                  iss_byte = {dev_q, 1'b1};
                  iss_next = PH_SLAR;
                end
              end
              PH_SLAR: begin
                if (st != ST_SLAR_ACK) begin
                  fin_en = 1'b1;
                end else begin
                  iss_en   = 1'b1;
                  iss_cmd  = (kind_q == KIND_RD_WORD) ? CMD_RD_ACK : CMD_RD_NACK;
                  iss_next = (kind_q == KIND_RD_WORD) ? PH_RDACK : PH_RDNACK;
                end
              end
              PH_RDACK: begin
                if (st != ST_RX_ACK) begin
                  fin_en = 1'b1;
                end else begin
                  acc_d    = it_i.edata;
                  iss_en   = 1'b1;
                  iss_cmd  = CMD_RD_NACK;
                  iss_next = PH_RDNACK;
                end
              end
              PH_RDNACK: begin
                fin_en = 1'b1;
                if (st == ST_RX_NACK) begin
                  fin_ok   = 1'b1;
                  fin_data = {acc_q, it_i.edata};
                end
              end
              default: ;
            endcase
          end
        end
        CLS_TICK: begin
          if (busy) begin
            if (wait_inc >= limit_q) begin
              // timeout: stop now, reinit from the pending flag once the result queue has room
              lock_d     = lock_q + 16'd1;
              phase_d    = PH_IDLE;
              wait_d     = 16'd0;
              pend_d     = 1'b1;
              res_push_o = 1'b1;
              res_o.cmd  = CMD_STOP;
              res_o.lock = lock_d;
              res_o.last = 1'b0;
            end else begin
              wait_d = wait_inc;
            end
          end
        end
        default: begin
          if (phase_q == PH_PAYLOAD) begin
            iss_en   = 1'b1;
            iss_cmd  = CMD_WRITE;
            iss_byte = it_i.word[7:0];
            iss_next = PH_BLK;
          end
        end
      endcase

      if (iss_en) begin
        phase_d        = iss_next;
        wait_d         = 16'd0;
        res_push_o     = 1'b1;
        res_o.cmd      = iss_cmd;
        res_o.cmd_byte = iss_byte;
      end else if (fin_en) begin
        phase_d    = PH_IDLE;
        res_push_o = 1'b1;
        res_o.cmd  = fin_stop ? CMD_STOP : CMD_NONE;
        res_o.done = 1'b1;
        res_o.ok   = fin_ok;
        res_o.data = fin_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      kind_q  <= '0;
      dev_q   <= '0;
      reg_q   <= '0;
      wval_q  <= '0;
      left_q  <= '0;
      acc_q   <= '0;
      wait_q  <= '0;
      lock_q  <= '0;
      limit_q <= TIMEOUT_RESET;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      wval_q  <= wval_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      wait_q  <= wait_d;
      lock_q  <= lock_d;
      limit_q <= limit_d;
      pend_q  <= pend_d;
    end
  end

endmodule

// ===== dv/tb_i2c_register_transaction_sequencer_top.sv =====
// Testbench for the I2C register transaction sequencer: a transaction predictor and
// scoreboard class, plus tasks that drive the queue-style ports with random pacing.
// Depends on i2cseq_pkg and i2c_register_transaction_sequencer_top.
package i2cseq_tb_pkg;
  import i2cseq_pkg::*;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_ADDR_WR,
    SEQ_REG,
    SEQ_DATA1,
    SEQ_DATA2,
    SEQ_PAYLOAD,
    SEQ_BLOCK,
    SEQ_RSTART,
    SEQ_ADDR_RD,
    SEQ_RD_ACK,
    SEQ_RD_NACK,
    SEQ_PING_ADDR
  } seq_phase_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  kind;
    logic [6:0]  dev;
    logic [7:0]  regad;
    logic [15:0] word;
    logic [7:0]  blen;
    logic [7:0]  status;
    logic [7:0]  edata;
  } bus_item_t;

  class txn_scoreboard;
    logic [15:0] timeout_limit;
    seq_phase_e  phase;
    logic [2:0]  active_kind;
    logic [6:0]  dev;
    logic [7:0]  regad;
    logic [15:0] wr_value;
    logic [7:0]  bytes_left;
    logic [15:0] rd_accum;
    logic [15:0] wait_ticks;
    logic [15:0] lockups;
    res_t        expected_q[$];
    res_t        fresh_q[$];
    int unsigned fail_count;

    function new();
      timeout_limit = TIMEOUT_RESET;
      phase         = SEQ_IDLE;
      active_kind   = '0;
      dev           = '0;
      regad         = '0;
      wr_value      = '0;
      bytes_left    = '0;
      rd_accum      = '0;
      wait_ticks    = '0;
      lockups       = '0;
      fail_count    = 0;
    endfunction

    function void emit(logic [2:0] cmd, logic [7:0] cbyte, logic done, logic ok,
                       logic [15:0] data);
      res_t r;
      r.cmd      = cmd;
      r.cmd_byte = cbyte;
      r.done     = done;
      r.ok       = ok;
      r.data     = data;
      r.lock     = lockups;
      r.last     = 1'b0;
      fresh_q.push_back(r);
    endfunction

    function void issue(logic [2:0] cmd, logic [7:0] cbyte, seq_phase_e next);
      phase      = next;
      wait_ticks = '0;
      emit(cmd, cbyte, 1'b0, 1'b0, '0);
    endfunction

    function void finish_txn(logic with_stop, logic ok, logic [15:0] data);
      phase = SEQ_IDLE;
      emit(with_stop ? CMD_STOP : CMD_NONE, 8'h00, 1'b1, ok, data);
    endfunction

    function void engine_done(logic [7:0] st, logic [7:0] rx);
      case (phase)
        SEQ_START: begin
          if (st != ST_START) finish_txn(active_kind == KIND_PING, 1'b0, '0);
          else issue(CMD_WRITE, {dev, 1'b0},
                     active_kind == KIND_PING ? SEQ_PING_ADDR : SEQ_ADDR_WR);
        end
        SEQ_PING_ADDR: finish_txn(1'b1, st == ST_SLAW_ACK, '0);
        SEQ_ADDR_WR: begin
          if (st != ST_SLAW_ACK) finish_txn(1'b1, 1'b0, '0);
          else issue(CMD_WRITE, regad, SEQ_REG);
        end
        SEQ_REG: begin
          if (st != ST_DATA_ACK) finish_txn(1'b1, 1'b0, '0);
          else if (active_kind == KIND_WR_BYTE) issue(CMD_WRITE, wr_value[7:0], SEQ_DATA1);
          else if (active_kind == KIND_WR_WORD) issue(CMD_WRITE, wr_value[15:8], SEQ_DATA1);
          else if (active_kind == KIND_WR_BLOCK) issue(CMD_WRITE, bytes_left, SEQ_DATA1);
          else issue(CMD_START, 8'h00, SEQ_RSTART);
        end
        SEQ_DATA1: begin
          if (st != ST_DATA_ACK) finish_txn(1'b1, 1'b0, '0);
          else if (active_kind == KIND_WR_WORD) issue(CMD_WRITE, wr_value[7:0], SEQ_DATA2);
          else if (active_kind == KIND_WR_BLOCK && bytes_left != 0) phase = SEQ_PAYLOAD;
          else finish_txn(1'b1, 1'b1, '0);
        end
        SEQ_DATA2: finish_txn(1'b1, st == ST_DATA_ACK, '0);
        SEQ_BLOCK: begin
          if (st != ST_DATA_ACK) begin
            finish_txn(1'b1, 1'b0, '0);
          end else begin
            bytes_left = bytes_left - 8'd1;
            if (bytes_left != 0) phase = SEQ_PAYLOAD;
            else finish_txn(1'b1, 1'b1, '0);
          end
        end
        SEQ_RSTART: begin
          // only a word read stops the bus after a refused repeated start
          if (st != ST_RSTART) finish_txn(active_kind == KIND_RD_WORD, 1'b0, '0);
          else issue(CMD_WRITE, {dev, 1'b1}, SEQ_ADDR_RD);
        end
        SEQ_ADDR_RD: begin
          if (st != ST_SLAR_ACK) finish_txn(1'b1, 1'b0, '0);
          else if (active_kind == KIND_RD_WORD) issue(CMD_RD_ACK, 8'h00, SEQ_RD_ACK);
          else issue(CMD_RD_NACK, 8'h00, SEQ_RD_NACK);
        end
        SEQ_RD_ACK: begin
          if (st != ST_RX_ACK) begin
            finish_txn(1'b1, 1'b0, '0);
          end else begin
            rd_accum = {8'h00, rx};
            issue(CMD_RD_NACK, 8'h00, SEQ_RD_NACK);
          end
        end
        SEQ_RD_NACK: begin
          if (st != ST_RX_NACK) begin
            finish_txn(1'b1, 1'b0, '0);
          end else begin
            rd_accum = {rd_accum[7:0], rx};
            finish_txn(1'b1, 1'b1, rd_accum);
          end
        end
        default: ;
      endcase
    endfunction

    // Advance the predicted state by one accepted item; return the number of results.
    function int note_item(bus_item_t it);
      res_t r;
      fresh_q.delete();
      case (it.mode)
        MODE_REQ: begin
          if (phase == SEQ_IDLE && it.kind <= KIND_PING) begin
            active_kind = it.kind;
            dev         = it.dev;
            regad       = it.regad;
            wr_value    = it.word;
            bytes_left  = it.blen;
            rd_accum    = '0;
            issue(CMD_START, 8'h00, SEQ_START);
          end
        end
        MODE_CPL: begin
          if (phase != SEQ_IDLE && phase != SEQ_PAYLOAD)
            engine_done(it.status & STATUS_MASK, it.edata);
        end
        MODE_TICK: begin
          if (phase != SEQ_IDLE && phase != SEQ_PAYLOAD) begin
            wait_ticks = wait_ticks + 16'd1;
            if (wait_ticks >= timeout_limit) begin
              lockups    = lockups + 16'd1;
              phase      = SEQ_IDLE;
              wait_ticks = '0;
              emit(CMD_STOP, 8'h00, 1'b0, 1'b0, '0);
              emit(CMD_REINIT, 8'h00, 1'b1, 1'b0, '0);
            end
          end
        end
        MODE_BYTE: begin
          if (phase == SEQ_PAYLOAD) issue(CMD_WRITE, it.word[7:0], SEQ_BLOCK);
        end
        default: ;
      endcase
      if (fresh_q.size() != 0) begin
        r = fresh_q.pop_back();
        r.last = 1'b1;
        fresh_q.push_back(r);
      end
      foreach (fresh_q[i]) expected_q.push_back(fresh_q[i]);
      return fresh_q.size();
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: command 0x%0h", got.cmd);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      check_field("command", want.cmd, got.cmd);
      check_field("command_byte", want.cmd_byte, got.cmd_byte);
      check_field("done_res", want.done, got.done);
      check_field("success", want.ok, got.ok);
      check_field("read_data", want.data, got.data);
      check_field("lockup_count", want.lock, got.lock);
      check_field("last", want.last, got.last);
    endfunction
  endclass

endpackage

module tb_i2c_register_transaction_sequencer_top;
  import i2cseq_pkg::*;
  import i2cseq_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned RANDOM_ITEMS = 222;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [1:0]  mode_i;
  logic [2:0]  kind_i;
  logic [6:0]  device_address_i;
  logic [7:0]  register_address_i;
  logic [15:0] data_word_i;
  logic [7:0]  block_length_i;
  logic [7:0]  engine_status_i;
  logic [7:0]  engine_data_i;
  logic        empty;
  logic        pop;
  logic [2:0]  command_o;
  logic [7:0]  command_byte_o;
  logic        done_res_o;
  logic        success_o;
  logic [15:0] read_data_o;
  logic [15:0] lockup_count_o;
  logic        last_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  txn_scoreboard sb;
  int unsigned   cycle_count = 0;
  int unsigned   burst_left;
  bit            hold_off_req = 1'b0;

  i2c_register_transaction_sequencer_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .mode_i             (mode_i),
    .kind_i             (kind_i),
    .device_address_i   (device_address_i),
    .register_address_i (register_address_i),
    .data_word_i        (data_word_i),
    .block_length_i     (block_length_i),
    .engine_status_i    (engine_status_i),
    .engine_data_i      (engine_data_i),
    .empty              (empty),
    .pop                (pop),
    .command_o          (command_o),
    .command_byte_o     (command_byte_o),
    .done_res_o         (done_res_o),
    .success_o          (success_o),
    .read_data_o        (read_data_o),
    .lockup_count_o     (lockup_count_o),
    .last_o             (last_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  always @(posedge clk_i) begin : result_monitor
    res_t got;
    if (rst_ni && pop && !empty) begin
      got.cmd      = command_o;
      got.cmd_byte = command_byte_o;
      got.done     = done_res_o;
      got.ok       = success_o;
      got.data     = read_data_o;
      got.lock     = lockup_count_o;
      got.last     = last_o;
      sb.check_result(got);
    end
  end

  // Receiver: pop on a random mask that is redrawn periodically, with an occasional long hold.
  initial begin : receiver
    logic [7:0]  mask;
    int unsigned hold_left;
    int unsigned slot;
    mask      = 8'hFF;
    hold_left = 0;
    slot      = 0;
    pop       = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_left    = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (slot % 64 == 0) begin
        mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom());
        if (mask == 8'h00) mask = 8'h01;
      end
      slot++;
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= mask[slot % 8];
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("i2c_register_transaction_sequencer_top test failed");
    $finish;
  end

  // Offer one item and hold it until the transfer; starts and ends at a falling edge.
  task automatic send_item(input bus_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    mode_i             <= it.mode;
    kind_i             <= it.kind;
    device_address_i   <= it.dev;
    register_address_i <= it.regad;
    data_word_i        <= it.word;
    block_length_i     <= it.blen;
    engine_status_i    <= it.status;
    engine_data_i      <= it.edata;
    push               <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    void'(sb.note_item(it));
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [1:0] m, input logic [2:0] k, input logic [6:0] d,
                             input logic [7:0] r, input logic [15:0] w, input logic [7:0] b,
                             input logic [7:0] s, input logic [7:0] e);
    bus_item_t it;
    it = '{mode: m, kind: k, dev: d, regad: r, word: w, blen: b, status: s, edata: e};
    send_item(it);
  endtask

  task automatic engine_reply(input logic [7:0] s, input logic [7:0] e);
    send_fields(MODE_CPL, KIND_WR_BYTE, 7'h00, 8'h00, 16'h0000, 8'h00, s, e);
  endtask

  // Stop offering and wait until every expected result has been popped.
  task automatic quiesce();
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.timeout_limit = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed traffic: the right status for the predicted phase, some noise.
  function automatic bus_item_t next_item();
    bus_item_t   it;
    logic [63:0] raw;
    logic [7:0]  ack;
    int unsigned roll;
    raw  = {$urandom(), $urandom()};
    it   = raw[59:0];
    roll = $urandom_range(0, 99);
    case (sb.phase)
      SEQ_START:                  ack = ST_START;
      SEQ_ADDR_WR, SEQ_PING_ADDR: ack = ST_SLAW_ACK;
      SEQ_RSTART:                 ack = ST_RSTART;
      SEQ_ADDR_RD:                ack = ST_SLAR_ACK;
      SEQ_RD_ACK:                 ack = ST_RX_ACK;
      SEQ_RD_NACK:                ack = ST_RX_NACK;
      default:                    ack = ST_DATA_ACK;
    endcase
    if (sb.phase == SEQ_IDLE) begin
      if (roll < 85) begin
        it.mode = MODE_REQ;
        it.kind = 3'($urandom_range(KIND_WR_BYTE, KIND_PING));
        // keep most blocks short, with the odd long one
        if (roll < 60) it.blen = 8'($urandom_range(0, 3));
        else if (roll < 78) it.blen = 8'($urandom_range(4, 16));
      end
    end else if (sb.phase == SEQ_PAYLOAD) begin
      if (roll < 80) it.mode = MODE_BYTE;
    end else if (roll < 65) begin
      it.mode = MODE_CPL;
      if ($urandom_range(0, 9) != 0) it.status = ack | 8'($urandom_range(0, 7));
    end else if (roll < 85) begin
      it.mode = MODE_TICK;
    end
    return it;
  endfunction

  initial begin : stimulus
    logic [15:0] limits [6];
    sb                 = new();
    rst_ni             = 1'b0;
    push               = 1'b0;
    mode_i             = MODE_REQ;
    kind_i             = KIND_WR_BYTE;
    device_address_i   = '0;
    register_address_i = '0;
    data_word_i        = '0;
    block_length_i     = '0;
    engine_status_i    = '0;
    engine_data_i      = '0;
    cfg_valid_i        = 1'b0;
    cfg_data_i         = '0;
    burst_left         = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // drop: traffic while idle and reserved kinds
    engine_reply(ST_START, 8'hFF);
    send_fields(MODE_TICK, KIND_WR_BYTE, 7'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
    send_fields(MODE_BYTE, KIND_WR_BYTE, 7'h00, 8'h00, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    send_fields(MODE_REQ, 3'd6, 7'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
    send_fields(MODE_REQ, 3'd7, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    // ping acked, status low bits set
    send_fields(MODE_REQ, KIND_PING, 7'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
    engine_reply(ST_START | 8'h07, 8'hFF);
    engine_reply(ST_SLAW_ACK, 8'h00);
    // read byte with a refused repeated start; a request in the middle is dropped
    send_fields(MODE_REQ, KIND_RD_BYTE, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 8'h00, 8'h00);
    send_fields(MODE_REQ, KIND_WR_WORD, 7'h12, 8'h34, 16'h5678, 8'h01, 8'h00, 8'h00);
    engine_reply(ST_START, 8'h00);
    engine_reply(ST_SLAW_ACK, 8'h00);
    engine_reply(ST_DATA_ACK, 8'h00);
    engine_reply(ST_START, 8'h00);
    // zero-length block: stop right after the length byte
    send_fields(MODE_REQ, KIND_WR_BLOCK, 7'h55, 8'hAA, 16'h1234, 8'h00, 8'h00, 8'h00);
    engine_reply(ST_START, 8'h00);
    engine_reply(ST_SLAW_ACK, 8'h00);
    engine_reply(ST_DATA_ACK, 8'h00);
    engine_reply(ST_DATA_ACK, 8'h00);
    // refused first start: done without stop, except for ping
    send_fields(MODE_REQ, KIND_WR_BYTE, 7'h2A, 8'h00, 16'h00FF, 8'h00, 8'h00, 8'h00);
    engine_reply(8'h00, 8'h00);
    send_fields(MODE_REQ, KIND_PING, 7'h7F, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
    engine_reply(ST_RSTART, 8'h00);

    // limit zero: one-byte block, then time out on the first counted tick
    quiesce();
    write_limit(16'd0);
    send_fields(MODE_REQ, KIND_WR_BLOCK, 7'h01, 8'h02, 16'h0000, 8'h01, 8'h00, 8'h00);
    engine_reply(ST_START, 8'h00);
    engine_reply(ST_SLAW_ACK, 8'h00);
    engine_reply(ST_DATA_ACK, 8'h00);
    engine_reply(ST_DATA_ACK, 8'h00);
    send_fields(MODE_TICK, KIND_WR_BYTE, 7'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
    engine_reply(ST_DATA_ACK, 8'h00);
    send_fields(MODE_BYTE, KIND_WR_BYTE, 7'h00, 8'h00, 16'h00FF, 8'h00, 8'h00, 8'h00);
    send_fields(MODE_BYTE, KIND_WR_BYTE, 7'h00, 8'h00, 16'hFF00, 8'h00, 8'h00, 8'h00);
    send_fields(MODE_TICK, KIND_WR_BYTE, 7'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);

    limits = '{16'd4, 16'd1, 16'hFFFF, 16'd2, 16'($urandom_range(3, 9)), TIMEOUT_RESET};
    foreach (limits[p]) begin
      quiesce();
      write_limit(limits[p]);
      if (p == 0 || p == 3) hold_off_req = 1'b1;
      repeat (RANDOM_ITEMS / 6) send_item(next_item());
    end

    quiesce();
    if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
      $display("i2c_register_transaction_sequencer_top test passed");
    end else begin
      $display("i2c_register_transaction_sequencer_top test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/i2cseq_pkg.sv
design/i2cseq_fifo.sv
design/i2cseq_front.sv
design/i2cseq_back.sv
design/i2c_register_transaction_sequencer_top.sv
dv/tb_i2c_register_transaction_sequencer_top.sv
